// File: sv/lsbse_pkg.sv
`default_nettype none
package lsbse_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned NUM_LANE = 3;

    localparam logic [CHAR_W-1:0] QUOTE_CHAR = 8'h22;

    typedef enum logic [1:0] {
        PH_OPEN   = 2'd0,
        PH_MSG    = 2'd1,
        PH_DONE   = 2'd2,
        PH_REJECT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_CLOSED  = 2'd1,
        ST_REJECT  = 2'd2,
        ST_UNTERM  = 2'd3
    } status_t;

    // what one lane reports for its bit slot
    typedef struct packed {
        logic              hit;
        logic              quote;
        logic [CHAR_W-1:0] value;
    } lane_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  acc;
        logic [COUNT_W-1:0] count;
        phase_t             phase;
    } xstate_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              char_valid;
        status_t           status;
    } result_t;

endpackage
`default_nettype wire

// File: sv/lsbse_lane.sv
`default_nettype none
// one bit slot of the pixel: would the char complete here, and with what byte
module lsbse_lane #(
    parameter int unsigned LANE = 0
) (
    input  wire logic [lsbse_pkg::CHAR_W-1:0]   acc,
    input  wire logic [lsbse_pkg::COUNT_W-1:0]  count,
    input  wire logic [lsbse_pkg::NUM_LANE-1:0] seq_bits,
    output lsbse_pkg::lane_t                    lane
);

    logic [lsbse_pkg::CHAR_W+lsbse_pkg::NUM_LANE-1:0] joined;

    assign joined = {acc, seq_bits} >> (lsbse_pkg::NUM_LANE - 1 - LANE);

    always_comb begin
        lane.value = joined[lsbse_pkg::CHAR_W-1:0];
        lane.hit   = (count == lsbse_pkg::COUNT_W'(lsbse_pkg::CHAR_W - 1 - LANE));
        lane.quote = (lane.value == lsbse_pkg::QUOTE_CHAR);
    end

endmodule
`default_nettype wire

// File: sv/lsbse_merge.sv
`default_nettype none
// picks the lane that completed a char and forms next state and result
module lsbse_merge (
    input  wire lsbse_pkg::lane_t                 lanes [lsbse_pkg::NUM_LANE],
    input  wire lsbse_pkg::xstate_t               cur,
    input  wire logic [lsbse_pkg::NUM_LANE-1:0]   seq_bits,
    input  wire logic                             last,
    output lsbse_pkg::xstate_t                    nxt,
    output lsbse_pkg::result_t                    res
);

    logic                          hit_any;
    logic                          sel_quote;
    logic [lsbse_pkg::CHAR_W-1:0]  sel_value;
    logic [lsbse_pkg::CHAR_W-1:0]  rem_acc;
    logic [lsbse_pkg::COUNT_W-1:0] rem_count;
    lsbse_pkg::xstate_t            upd;

    always_comb begin
        hit_any   = 1'b0;
        sel_quote = 1'b0;
        sel_value = '0;
        rem_acc   = '0;
        rem_count = '0;
        if (lanes[0].hit) begin
            hit_any   = 1'b1;
            sel_quote = lanes[0].quote;
            sel_value = lanes[0].value;
            rem_acc   = {6'd0, seq_bits[1:0]};
            rem_count = 3'd2;
        end else if (lanes[1].hit) begin
            hit_any   = 1'b1;
            sel_quote = lanes[1].quote;
            sel_value = lanes[1].value;
            rem_acc   = {7'd0, seq_bits[0]};
            rem_count = 3'd1;
        end else if (lanes[2].hit) begin
            hit_any   = 1'b1;
            sel_quote = lanes[2].quote;
            sel_value = lanes[2].value;
        end
    end

    always_comb begin
        upd            = cur;
        res.char_out   = '0;
        res.char_valid = 1'b0;
        if (cur.phase == lsbse_pkg::PH_OPEN || cur.phase == lsbse_pkg::PH_MSG) begin
            if (hit_any) begin
                upd.acc   = rem_acc;
                upd.count = rem_count;
                if (cur.phase == lsbse_pkg::PH_OPEN) begin
                    upd.phase = sel_quote ? lsbse_pkg::PH_MSG : lsbse_pkg::PH_REJECT;
                end else if (sel_quote) begin
                    upd.phase = lsbse_pkg::PH_DONE;
                end else begin
                    res.char_out   = sel_value;
                    res.char_valid = 1'b1;
                end
                if (upd.phase == lsbse_pkg::PH_DONE || upd.phase == lsbse_pkg::PH_REJECT) begin
                    upd.acc   = '0;
                    upd.count = '0;
                end
            end else begin
                upd.acc   = {cur.acc[lsbse_pkg::CHAR_W-lsbse_pkg::NUM_LANE-1:0], seq_bits};
                upd.count = cur.count + lsbse_pkg::COUNT_W'(lsbse_pkg::NUM_LANE);
            end
        end

        case (upd.phase)
            lsbse_pkg::PH_DONE:   res.status = lsbse_pkg::ST_CLOSED;
            lsbse_pkg::PH_REJECT: res.status = lsbse_pkg::ST_REJECT;
            default:              res.status = lsbse_pkg::ST_RUNNING;
        endcase

        nxt = upd;
        if (last) begin
            if (upd.phase == lsbse_pkg::PH_OPEN || upd.phase == lsbse_pkg::PH_MSG) begin
                res.status = lsbse_pkg::ST_UNTERM;
            end
            nxt.acc   = '0;
            nxt.count = '0;
            nxt.phase = lsbse_pkg::PH_OPEN;
        end
    end

endmodule
`default_nettype wire

// File: sv/lsb_stego_message_extractor.sv
// lsb steganography message extractor: one rgb pixel per input beat, one result beat per
// pixel. the lsbs of the three channels (blue, green, red, or red, green, blue when
// cfg_data is 1) are shifted msb-first into 8-bit chars. the first char of an image must
// be a double quote or the message is rejected; later chars come out with char_valid set
// until a closing quote, and neither quote is emitted. after the outcome, pixels only
// report the sticky status until the tlast pixel, which re-arms the block and drops any
// partial bits; a tlast pixel with no outcome yet reports unterminated. throughput is one
// pixel per clock unless m_tready stalls the output: the three bit slots are evaluated by
// three lanes in parallel and merged in the same cycle, and the result sits in one output
// register that still accepts a new pixel in the cycle it is taken. the block does not
// gate the always-ready cfg channel: write channel order only while no pixel is in flight.
`default_nettype none
module lsb_stego_message_extractor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,     // channel_order
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,      // chan_red[7:0], chan_green[15:8], chan_blue[23:16]
    input  wire logic        s_tlast,      // last_pixel
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,      // char_out[7:0]
    output logic [2:0]       m_tuser       // char_valid[0], status[2:1]
);

    logic                                 order_reg;
    lsbse_pkg::xstate_t                   st_reg;
    lsbse_pkg::xstate_t                   st_next;
    lsbse_pkg::result_t                   res_reg;
    lsbse_pkg::result_t                   res_next;
    logic                                 m_valid_reg;
    logic [lsbse_pkg::NUM_LANE-1:0]       seq_bits;
    lsbse_pkg::lane_t                     lanes [lsbse_pkg::NUM_LANE];
    logic                                 s_beat;

    assign cfg_ready = 1'b1;
    // output register frees up in the cycle its beat is taken
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_beat    = s_tvalid && s_tready;

    // first bit in the msb of the slot vector
    assign seq_bits = order_reg ? {s_tdata[0], s_tdata[8], s_tdata[16]}
                                : {s_tdata[16], s_tdata[8], s_tdata[0]};

    // one lane per bit slot of the pixel
    for (genvar k = 0; k < lsbse_pkg::NUM_LANE; k++) begin : g_lane
        lsbse_lane #(
            .LANE(k)
        ) u_lane (
            .acc     (st_reg.acc),
            .count   (st_reg.count),
            .seq_bits(seq_bits),
            .lane    (lanes[k])
        );
    end

    lsbse_merge u_merge (
        .lanes   (lanes),
        .cur     (st_reg),
        .seq_bits(seq_bits),
        .last    (s_tlast),
        .nxt     (st_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg   <= 1'b0;
            st_reg      <= '{acc: '0, count: '0, phase: lsbse_pkg::PH_OPEN};
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                order_reg <= cfg_data;
            end
            if (s_beat) begin
                st_reg <= st_next;
            end
            if (s_beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg.char_out;
    assign m_tuser  = {res_reg.status, res_reg.char_valid};

`ifndef SYNTH
    // a char only comes out while the message is open
    a_valid_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.char_valid |->
            (res_reg.status == lsbse_pkg::ST_RUNNING || res_reg.status == lsbse_pkg::ST_UNTERM))
        else $error("char emitted with final status");

    // no stray data without a char
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !res_reg.char_valid |-> res_reg.char_out == '0)
        else $error("char_out nonzero without char_valid");

    // a last pixel re-arms the image state
    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && s_tlast |=>
            st_reg.phase == lsbse_pkg::PH_OPEN && st_reg.count == '0 && st_reg.acc == '0)
        else $error("image state not cleared after last pixel");

    // once the outcome is known no bits are collected
    a_idle_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == lsbse_pkg::PH_DONE || st_reg.phase == lsbse_pkg::PH_REJECT) |->
            st_reg.count == '0)
        else $error("bits collected after message end");
`endif

endmodule
`default_nettype wire

// File: tb/lsbse_result_checker.sv
`timescale 1ns / 1ps
module lsbse_result_checker
    import lsbse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic [2:0]  m_tuser,
    output int               n_mismatch,
    output int               n_pending,
    output int               n_checked
);

    logic              rgb_order;
    logic [CHAR_W-1:0] char_acc;
    int                bits_held;
    phase_t            msg_phase;
    result_t           pending_results [$];

    initial begin
        n_mismatch = 0;
        n_pending  = 0;
        n_checked  = 0;
    end

    // expected result of one pixel, advancing the extraction state
    function automatic result_t decode_pixel(input logic [23:0] px, input logic last);
        logic    lsb [3];
        result_t res;
        res = '0;
        res.status = ST_RUNNING;
        if (rgb_order) begin
            lsb[0] = px[0];  lsb[1] = px[8]; lsb[2] = px[16];
        end else begin
            lsb[0] = px[16]; lsb[1] = px[8]; lsb[2] = px[0];
        end
        for (int k = 0; k < 3; k++) begin
            if (msg_phase == PH_OPEN || msg_phase == PH_MSG) begin
                char_acc  = {char_acc[CHAR_W-2:0], lsb[k]};
                bits_held = bits_held + 1;
                if (bits_held == CHAR_W) begin
                    if (msg_phase == PH_OPEN)
                        msg_phase = (char_acc == QUOTE_CHAR) ? PH_MSG : PH_REJECT;
                    else if (char_acc == QUOTE_CHAR)
                        msg_phase = PH_DONE;
                    else begin
                        res.char_out   = char_acc;
                        res.char_valid = 1'b1;
                    end
                    char_acc  = '0;
                    bits_held = 0;
                end
            end
        end
        case (msg_phase)
            PH_DONE:   res.status = ST_CLOSED;
            PH_REJECT: res.status = ST_REJECT;
            default:   res.status = ST_RUNNING;
        endcase
        if (last) begin
            if (msg_phase == PH_OPEN || msg_phase == PH_MSG)
                res.status = ST_UNTERM;
            char_acc  = '0;
            bits_held = 0;
            msg_phase = PH_OPEN;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            rgb_order = 1'b0;
            char_acc  = '0;
            bits_held = 0;
            msg_phase = PH_OPEN;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                rgb_order = cfg_data;
            // compare before queuing, so a stray beat never matches this edge's pixel
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: unexpected result beat char=%02h valid=%0b status=%0d",
                                 $realtime, m_tdata, m_tuser[0], m_tuser[2:1]);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.char_out || m_tuser[0] !== want.char_valid ||
                        m_tuser[2:1] !== want.status) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"%0t: mismatch exp char=%02h valid=%0b status=%0d,",
                                      " got char=%02h valid=%0b status=%0d"},
                                     $realtime, want.char_out, want.char_valid, want.status,
                                     m_tdata, m_tuser[0], m_tuser[2:1]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(decode_pixel(s_tdata, s_tlast));
        end
        n_pending = pending_results.size();
    end

endmodule

// File: tb/lsb_stego_message_extractor_test.sv
`timescale 1ns / 1ps
module lsb_stego_message_extractor_test;
    import lsbse_pkg::*;

    typedef enum int {
        IMG_GOOD,        // opening quote, text, closing quote
        IMG_BAD_HEADER,  // first char is not a quote
        IMG_OPEN_END,    // opening quote and text, image ends before the close
        IMG_NOISE        // random bits of random length
    } image_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_data;
    wire logic   cfg_ready;
    logic        s_tvalid;
    wire logic   s_tready;
    logic [23:0] s_tdata;     // chan_red[7:0], chan_green[15:8], chan_blue[23:16]
    logic        s_tlast;     // last_pixel
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [7:0] m_tdata; // char_out[7:0]
    wire logic [2:0] m_tuser; // char_valid[0], status[2:1]

    int n_mismatch;
    int n_pending;
    int n_checked;

    // idle and stall rates in percent, changed per phase
    int idle_pct  = 0;
    int stall_pct = 0;
    logic cur_order = 1'b0;
    int n_pixels = 0;
    int n_images = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lsb_stego_message_extractor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    lsbse_result_checker i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .n_mismatch (n_mismatch),
        .n_pending  (n_pending),
        .n_checked  (n_checked)
    );

    // receiver backpressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // one pixel beat; returns on the edge that accepted it
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic last);
        bit hs;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        s_tlast  <= last;
        // inputs only move at the rising edge, so tready seen at the falling edge holds
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
        n_pixels++;
    endtask

    // channel order write, only called with nothing in flight
    task automatic write_order(input logic order);
        bit hs;
        cfg_valid <= 1'b1;
        cfg_data  <= order;
        do begin
            @(negedge aclk);
            hs = cfg_ready;
            @(posedge aclk);
        end while (!hs);
        cfg_valid <= 1'b0;
        cur_order = order;
    endtask

    // wait for every expected result, then idle on to catch stray beats
    task automatic drain;
        s_tvalid <= 1'b0;
        // let the checker see the last accepted beat first
        @(negedge aclk);
        while (n_pending != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic void push_char(ref bit msg_bits [$], input logic [7:0] c);
        for (int i = 7; i >= 0; i--)
            msg_bits.push_back(c[i]);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == QUOTE_CHAR)
            c = c ^ 8'h01;
        return c;
    endfunction

    // builds the bit stream of one image and sends it as pixels, last one marked
    task automatic send_image(input image_kind_t kind, input int nchars, input int extra_px);
        bit         msg_bits [$];
        logic [7:0] c;
        logic [7:0] red, green, blue;
        int         npx;
        case (kind)
            IMG_GOOD: begin
                push_char(msg_bits, QUOTE_CHAR);
                for (int i = 0; i < nchars; i++)
                    push_char(msg_bits, text_char());
                push_char(msg_bits, QUOTE_CHAR);
            end
            IMG_BAD_HEADER: begin
                c = text_char();
                push_char(msg_bits, c);
                for (int i = 0; i < nchars; i++)
                    push_char(msg_bits, text_char());
            end
            IMG_OPEN_END: begin
                push_char(msg_bits, QUOTE_CHAR);
                for (int i = 0; i < nchars; i++)
                    push_char(msg_bits, text_char());
                // partial char left behind
                repeat ($urandom_range(0, 7)) msg_bits.push_back(1'($urandom_range(0, 1)));
            end
            default: begin
                repeat ($urandom_range(1, 40)) msg_bits.push_back(1'($urandom_range(0, 1)));
            end
        endcase
        while (msg_bits.size() % 3 != 0)
            msg_bits.push_back(1'($urandom_range(0, 1)));
        repeat (3 * extra_px) msg_bits.push_back(1'($urandom_range(0, 1)));
        npx = msg_bits.size() / 3;
        for (int p = 0; p < npx; p++) begin
            red   = 8'($urandom);
            green = 8'($urandom);
            blue  = 8'($urandom);
            green[0] = msg_bits[3*p+1];
            if (cur_order) begin
                red[0]  = msg_bits[3*p];
                blue[0] = msg_bits[3*p+2];
            end else begin
                blue[0] = msg_bits[3*p];
                red[0]  = msg_bits[3*p+2];
            end
            send_pixel(red, green, blue, p == npx - 1);
        end
        n_images++;
    endtask

    // hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int          phase_px;
        int          pick;
        image_kind_t kind;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: all-zero and all-one pixels, last with only partial bits
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
        // header of 0xff gets rejected mid-pixel, status sticks through the last pixel
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        // one-char message in reset order, then in rgb order
        send_image(IMG_GOOD, 1, 0);
        drain();
        write_order(1'b1);
        send_image(IMG_GOOD, 1, 0);
        drain();

        // random images: four idle/stall mixes, each with both channel orders
        for (int ph = 0; ph < 8; ph++) begin
            write_order(ph < 4);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            phase_px = n_pixels;
            while (n_pixels - phase_px < 230) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    kind = IMG_GOOD;
                else if (pick < 80)
                    kind = IMG_BAD_HEADER;
                else if (pick < 90)
                    kind = IMG_OPEN_END;
                else
                    kind = IMG_NOISE;
                send_image(kind, $urandom_range(0, 12), $urandom_range(0, 2));
            end
            drain();
        end

        $display("sent %0d pixels in %0d images, both channel orders, four idle/stall mixes",
                 n_pixels, n_images);
        $display("checked %0d result beats, %0d mismatches", n_checked, n_mismatch);
        if (n_mismatch == 0 && n_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
